/* design/distance_vector_route_update_core_defines.svh */
// Assertion macros for the route update core RTL (used by dvru_back).
`ifndef DISTANCE_VECTOR_ROUTE_UPDATE_CORE_DEFINES_SVH
`define DISTANCE_VECTOR_ROUTE_UPDATE_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset.
`define DVRU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define DVRU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/dvru_pkg.sv */
// Types and constants of the route update core.
package dvru_pkg;

	localparam int NODE_COUNT  = 128;
	localparam int NODE_W      = 7;
	localparam int TABLE_DEPTH = 1 << NODE_W;
	localparam int COST_W      = 16;
	localparam int ENTRY_W     = COST_W + NODE_W;
	localparam int WALK_W      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

	localparam logic [COST_W-1:0] COST_MAX = '1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int FIELDS_W   = 2 * NODE_W + COST_W;
	localparam int IN_DATA_W  = ((FIELDS_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((FIELDS_W + 7) / 8) * 8;
	localparam int SRC_LSB    = 0;
	localparam int DST_LSB    = NODE_W;
	localparam int COST_LSB   = 2 * NODE_W;

	typedef enum logic [1:0] {
		KIND_OWN,
		KIND_LINK,
		KIND_ADV
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [NODE_W-1:0]  src;
		logic [NODE_W-1:0]  dst;
		logic [COST_W-1:0]  cost;
	} item_t;

	typedef struct packed {
		logic [NODE_W-1:0]  dst;
		logic [COST_W-1:0]  cost;
		logic [NODE_W-1:0]  hop;
		logic               changed;
		logic               fault;
	} res_t;

endpackage

/* design/distance_vector_route_update_core.sv */
// Top level of the route update core: configuration register and channel packing.
//
// Keeps the routing table of one router. Requests enter on the s_ channel:
// tuser is the mode (0 direct link, 1 neighbor advertisement), tdata carries
// source_node, dest_node and route_cost. Every request yields exactly one
// result on the m_ channel: tdata carries dest_echo, best_cost and first_hop,
// tuser carries changed and fault.
// cfg_data sets own_node; write it only while no request is in flight.
// A two-entry queue decouples the input from the table engine, and a result
// register decouples the engine from the receiver. A stalled receiver leaves
// one result in that register, one in the engine and two requests queued
// before s_tready drops.
// Engine path per request: no table read when dest_node is own_node; a read of
// the dest_node entry for a link or an advertisement from an unknown or own
// source; that read and a read of the source entry for an advertisement that
// does not improve; and after those, the first-hop walk, which reads k entries
// (k up to NODE_COUNT), whether it succeeds or faults.
// Every table read and every walk step uses the single RAM read port.
// Reset clears all known flags at once and sets own_node to 0; no sweep.
module distance_vector_route_update_core import dvru_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [NODE_W-1:0]     cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // source_node, dest_node, route_cost, zero pad
	input  logic                  s_tuser,   // mode
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // dest_echo, best_cost, first_hop, zero pad
	output logic [1:0]            m_tuser    // changed, fault
);

	logic [NODE_W-1:0] own_node_q;
	logic              q_valid;
	item_t             q_item;
	logic              q_pop;
	res_t              out_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_node_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			own_node_q <= cfg_data;
		end
	end

	dvru_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.own_node (own_node_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	dvru_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.own_node  (own_node_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {{(OUT_DATA_W - FIELDS_W){1'b0}}, out_res.hop, out_res.cost, out_res.dst};
	assign m_tuser = {out_res.fault, out_res.changed};

endmodule

/* design/dvru_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dvru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* design/dvru_front.sv */
// Front end: accepts requests, classifies them and queues them for the back end.
module dvru_front import dvru_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [NODE_W-1:0]    own_node,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	input  logic                 s_tuser,
	output logic                 q_valid,
	output item_t                q_item,
	input  logic                 q_pop
);

	item_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;
	item_t             in_item;

	always_comb begin
		in_item.src  = s_tdata[SRC_LSB +: NODE_W];
		in_item.dst  = s_tdata[DST_LSB +: NODE_W];
		in_item.cost = s_tdata[COST_LSB +: COST_W];
		if (in_item.dst == own_node) begin
			in_item.kind = KIND_OWN;
		end else if (s_tuser) begin
			in_item.kind = KIND_ADV;
		end else begin
			in_item.kind = KIND_LINK;
		end
	end

	assign s_tready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign q_valid  = (cnt_q != '0);
	assign q_item   = slot_q[rd_ptr_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

/* design/dvru_back.sv */
// Back end: table read-modify-write, first-hop walk and the output register.
`include "distance_vector_route_update_core_defines.svh"

module dvru_back import dvru_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [NODE_W-1:0] own_node,
	input  logic              q_valid,
	input  item_t             q_item,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output res_t              out_res
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_RD_DST = 3'd1;
	localparam logic [2:0] S_RD_SRC = 3'd2;
	localparam logic [2:0] S_WALK   = 3'd3;
	localparam logic [2:0] S_OUT    = 3'd4;

	logic [2:0]             state_q, state_d;
	logic [TABLE_DEPTH-1:0] known_q;
	item_t                  cur_q;
	logic [COST_W-1:0]      dcost_q;
	logic [NODE_W-1:0]      dhop_q;
	logic [COST_W-1:0]      sum_q;
	logic [NODE_W-1:0]      hop_q;
	logic [WALK_W-1:0]      cnt_q;
	res_t                   res_q, res_d;
	logic                   out_valid_q;
	res_t                   out_res_q;

	logic                   rd_en, wr_en;
	logic [NODE_W-1:0]      rd_addr;
	logic [ENTRY_W-1:0]     rd_data, wr_data;
	logic [COST_W-1:0]      rd_cost;
	logic [NODE_W-1:0]      rd_hop;

	logic                   res_load, set_known, walk_start, walk_adv, out_load;
	logic                   dst_known, src_bad, link_upd, adv_upd;
	logic                   hop_self, walk_limit, next_bad;
	logic [COST_W:0]        sum_wide;
	logic [COST_W-1:0]      sum_sat;

	dvru_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cur_q.dst),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rd_cost    = rd_data[ENTRY_W-1:NODE_W];
	assign rd_hop     = rd_data[NODE_W-1:0];
	assign dst_known  = known_q[cur_q.dst];
	assign src_bad    = (cur_q.src == own_node) || !known_q[cur_q.src];
	assign link_upd   = !dst_known || (rd_cost > cur_q.cost);
	assign sum_wide   = {1'b0, rd_cost} + {1'b0, cur_q.cost};
	assign sum_sat    = sum_wide[COST_W] ? COST_MAX : sum_wide[COST_W-1:0];
	assign adv_upd    = !dst_known || (dcost_q > sum_sat);
	assign hop_self   = (rd_hop == hop_q);
	assign walk_limit = (cnt_q == WALK_W'(NODE_COUNT - 1));
	assign next_bad   = (rd_hop == own_node) || !known_q[rd_hop];
	assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = cur_q.src;
		wr_en      = 1'b0;
		wr_data    = {cur_q.cost, cur_q.dst};
		res_load   = 1'b0;
		res_d      = '{dst: cur_q.dst, cost: '0, hop: '0, changed: 1'b0, fault: 1'b0};
		set_known  = 1'b0;
		walk_start = 1'b0;
		walk_adv   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_item.kind == KIND_OWN) begin
						res_load  = 1'b1;
						res_d.dst = q_item.dst;
						res_d.hop = own_node;
						state_d   = S_OUT;
					end else begin
						rd_en   = 1'b1;
						rd_addr = q_item.dst;
						state_d = S_RD_DST;
					end
				end
			end
			S_RD_DST: begin
				res_load = 1'b1;
				state_d  = S_OUT;
				if (dst_known) begin
					res_d.cost = rd_cost;
					res_d.hop  = rd_hop;
				end
				if (cur_q.kind == KIND_LINK) begin
					if (link_upd) begin
						wr_en         = 1'b1;
						set_known     = 1'b1;
						res_d.cost    = cur_q.cost;
						res_d.hop     = cur_q.dst;
						res_d.changed = 1'b1;
					end
				end else if (src_bad) begin
					res_d.fault = 1'b1;
				end else begin
					res_load = 1'b0;
					rd_en    = 1'b1;
					state_d  = S_RD_SRC;
				end
			end
			S_RD_SRC: begin
				if (adv_upd) begin
					// first hop: follow next hops from the advertising neighbour
					rd_en      = 1'b1;
					walk_start = 1'b1;
					state_d    = S_WALK;
				end else begin
					res_load = 1'b1;
					if (dst_known) begin
						res_d.cost = dcost_q;
						res_d.hop  = dhop_q;
					end
					state_d = S_OUT;
				end
			end
			S_WALK: begin
				if (hop_self) begin
					wr_en         = 1'b1;
					wr_data       = {sum_q, hop_q};
					set_known     = 1'b1;
					res_load      = 1'b1;
					res_d.cost    = sum_q;
					res_d.hop     = hop_q;
					res_d.changed = 1'b1;
					state_d       = S_OUT;
				end else if (walk_limit || next_bad) begin
					res_load    = 1'b1;
					res_d.fault = 1'b1;
					if (dst_known) begin
						res_d.cost = dcost_q;
						res_d.hop  = dhop_q;
					end
					state_d = S_OUT;
				end else begin
					rd_en    = 1'b1;
					rd_addr  = rd_hop;
					walk_adv = 1'b1;
				end
			end
			S_OUT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			known_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (set_known) begin
				known_q[cur_q.dst] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_item;
		end
		if (state_q == S_RD_DST) begin
			dcost_q <= rd_cost;
			dhop_q  <= rd_hop;
		end
		if (state_q == S_RD_SRC) begin
			sum_q <= sum_sat;
		end
		if (walk_start) begin
			hop_q <= cur_q.src;
			cnt_q <= '0;
		end else if (walk_adv) begin
			hop_q <= rd_hop;
			cnt_q <= cnt_q + 1'b1;
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if (out_load) begin
			out_res_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	`DVRU_ASSERT_NOW(a_wr_state, wr_en, (state_q == S_RD_DST) || (state_q == S_WALK), "table write outside update state")
	`DVRU_ASSERT_NOW(a_walk_known, state_q == S_WALK, known_q[hop_q] && (hop_q != own_node), "walk on unknown or own entry")
	`DVRU_ASSERT_NOW(a_res_flags, out_valid_q, !(out_res_q.changed && out_res_q.fault), "result both changed and faulted")
	`DVRU_ASSERT_NEXT(a_pop_leave, q_pop, state_q != S_IDLE, "pop did not start an item")

endmodule
